[rtl/core/cc_pkg.sv]
// Shared types, constants and the ChaCha half quarter-round function.
`timescale 1ns / 1ps

package cc_pkg;

    localparam int ROUND_COUNT_DEF = 20;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] SIGMA_0 = 32'h65787061;
    localparam logic [31:0] SIGMA_1 = 32'h6e642033;
    localparam logic [31:0] SIGMA_2 = 32'h322d6279;
    localparam logic [31:0] SIGMA_3 = 32'h7465206b;

    localparam logic [63:0] BLOCK_STEP = 64'd64;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_KEY_0_7   = 3'd0;
    localparam logic [2:0] REG_KEY_8_15  = 3'd1;
    localparam logic [2:0] REG_KEY_16_23 = 3'd2;
    localparam logic [2:0] REG_KEY_24_31 = 3'd3;
    localparam logic [2:0] REG_NONCE     = 3'd4;
    localparam logic [2:0] REG_START     = 3'd5;

    typedef logic [15:0][31:0] block_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  index;
        logic [63:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic emit;
        logic cur_valid;
        logic eng_busy;
        logic eng_done;
    } back_status_t;

    // One half of a quarter-round on all four lanes at once.
    // second = 0: rotate by 16 and 12; second = 1: rotate by 8 and 7.
    function automatic block_t cc_half_round(block_t w_in, logic diag, logic second);
        block_t     w;
        logic [1:0] lane;
        logic [3:0] ia;
        logic [3:0] ib;
        logic [3:0] ic;
        logic [3:0] id;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        w = w_in;
        for (int i = 0; i < 4; i++)
        begin
            lane = i[1:0];
            ia = {2'b00, lane};
            ib = {2'b01, 2'(lane + (diag ? 2'd1 : 2'd0))};
            ic = {2'b10, 2'(lane + (diag ? 2'd2 : 2'd0))};
            id = {2'b11, 2'(lane + (diag ? 2'd3 : 2'd0))};
            a = w[ia];
            b = w[ib];
            c = w[ic];
            d = w[id];
            a = a + b;
            d = d ^ a;
            d = second ? {d[23:0], d[31:24]} : {d[15:0], d[31:16]};
            c = c + d;
            b = b ^ c;
            b = second ? {b[24:0], b[31:25]} : {b[19:0], b[31:20]};
            w[ia] = a;
            w[ib] = b;
            w[ic] = c;
            w[id] = d;
        end
        return w;
    endfunction

endpackage

[rtl/core/cc_front.sv]
// Input side: accept byte requests and queue them for the cipher back end.
`timescale 1ns / 1ps

module cc_front
    import cc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_data,
    input  logic       in_first,
    input  logic       in_last,
    output logic       head_valid,
    output item_t      head,
    input  logic       pop
);

    item_t                q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;
    logic                 push;
    logic                 do_pop;

    assign in_ready   = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign push       = in_valid && in_ready;
    assign do_pop     = pop && head_valid;
    assign head       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= '{data: in_data, first: in_first, last: in_last};
        end
    end

endmodule

[rtl/core/cc_core.sv]
// Iterative ChaCha round engine: half a quarter-round per cycle on four lanes.
`timescale 1ns / 1ps

module cc_core
    import cc_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  block_t init_in,
    output logic   busy,
    output logic   done,
    output block_t result
);

    localparam int SW = $clog2(2 * ROUND_COUNT + 1);
    localparam logic [SW-1:0] LAST_STEP = SW'(2 * ROUND_COUNT);

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    block_t        work_reg;
    block_t        init_reg;
    block_t        result_reg;
    logic          at_end;

    assign at_end = (step_reg == LAST_STEP);
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (at_end)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Round parity picks column or diagonal; step bit 0 picks the half.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            work_reg <= init_in;
            init_reg <= init_in;
        end
        else if (busy_reg && !at_end)
        begin
            work_reg <= cc_half_round(work_reg, step_reg[1], step_reg[0]);
        end
        if (busy_reg && at_end)
        begin
            for (int k = 0; k < 16; k++)
            begin
                result_reg[k] <= work_reg[k] + init_reg[k];
            end
        end
    end

endmodule

[rtl/core/cc_back.sv]
// Cipher back end: key registers, keystream blocks, byte XOR and output register.
`timescale 1ns / 1ps

module cc_back
    import cc_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_wr_t      cfg_wr,
    input  logic         head_valid,
    input  item_t        head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   out_data,
    output logic         out_last,
    output back_status_t status
);

    logic [3:0][63:0] key_reg;
    logic [3:0][63:0] key_next;
    logic [63:0]      nonce_reg;
    logic [63:0]      nonce_next;
    logic [63:0]      start_reg;
    logic [63:0]      start_next;
    logic [63:0]      pos_reg;
    logic [63:0]      pos_next;
    logic [5:0]       offset_reg;
    logic [5:0]       offset_next;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic             nxt_valid_reg;
    logic             nxt_valid_next;
    block_t           cur_ks_reg;
    block_t           cur_ks_next;
    block_t           nxt_ks_reg;
    block_t           nxt_ks_next;
    logic             job_cur_reg;
    logic             job_cur_next;
    logic             cancel_reg;
    logic             cancel_next;
    logic             restarted_reg;
    logic             restarted_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_data_reg;
    logic [7:0]       out_data_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic             cfg_hit;
    logic             restart;
    logic             emit;
    logic             block_end;
    logic             eng_start;
    logic             eng_busy;
    logic             eng_done;
    block_t           eng_result;
    block_t           init_blk;
    logic [63:0]      job_pos;
    logic [31:0]      ks_word;
    logic [7:0]       ks_byte;

    cc_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (eng_start),
        .init_in (init_blk),
        .busy    (eng_busy),
        .done    (eng_done),
        .result  (eng_result)
    );

    assign cfg_hit   = cfg_wr.valid && (cfg_wr.index <= REG_START);
    assign restart   = head_valid && head.first && !restarted_reg;
    assign emit      = head_valid && !restart && cur_valid_reg
                       && (!out_valid_reg || out_ready);
    assign block_end = emit && (offset_reg == 6'd63);
    assign pop       = emit;

    assign ks_word = cur_ks_reg[offset_reg[5:2]];
    assign ks_byte = ks_word[{offset_reg[1:0], 3'b000} +: 8];

    // Build the next block only when nothing this cycle moves the position.
    assign eng_start = !eng_busy && !eng_done && !cfg_hit && !restart && !block_end
                       && (!cur_valid_reg || !nxt_valid_reg);
    assign job_pos   = cur_valid_reg ? pos_reg + BLOCK_STEP : pos_reg;

    always_comb
    begin
        init_blk[0] = SIGMA_0;
        init_blk[1] = SIGMA_1;
        init_blk[2] = SIGMA_2;
        init_blk[3] = SIGMA_3;
        for (int i = 0; i < 4; i++)
        begin
            init_blk[4 + 2 * i] = key_reg[i][31:0];
            init_blk[5 + 2 * i] = key_reg[i][63:32];
        end
        init_blk[12] = job_pos[63:32];
        init_blk[13] = job_pos[31:0];
        init_blk[14] = nonce_reg[63:32];
        init_blk[15] = nonce_reg[31:0];
    end

    always_comb
    begin
        key_next       = key_reg;
        nonce_next     = nonce_reg;
        start_next     = start_reg;
        pos_next       = pos_reg;
        offset_next    = offset_reg;
        cur_valid_next = cur_valid_reg;
        nxt_valid_next = nxt_valid_reg;
        cur_ks_next    = cur_ks_reg;
        nxt_ks_next    = nxt_ks_reg;
        job_cur_next   = job_cur_reg;
        cancel_next    = cancel_reg;
        restarted_next = restarted_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        // A register write drops the prefetched block; the current one stays
        // if a byte has already been taken from it.
        if (cfg_hit)
        begin
            case (cfg_wr.index)
                REG_KEY_0_7:   key_next[0] = cfg_wr.data;
                REG_KEY_8_15:  key_next[1] = cfg_wr.data;
                REG_KEY_16_23: key_next[2] = cfg_wr.data;
                REG_KEY_24_31: key_next[3] = cfg_wr.data;
                REG_NONCE:     nonce_next  = cfg_wr.data;
                REG_START:     start_next  = cfg_wr.data;
                default:       nonce_next  = nonce_reg;
            endcase
            nxt_valid_next = 1'b0;
            if (offset_reg == 6'd0)
            begin
                cur_valid_next = 1'b0;
            end
            if (eng_busy)
            begin
                cancel_next = 1'b1;
            end
        end

        if (restart)
        begin
            pos_next       = start_reg;
            offset_next    = 6'd0;
            cur_valid_next = 1'b0;
            nxt_valid_next = 1'b0;
            restarted_next = 1'b1;
            if (eng_busy)
            begin
                cancel_next = 1'b1;
            end
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = head.data ^ ks_byte;
            out_last_next  = head.last;
            offset_next    = offset_reg + 6'd1;
            restarted_next = 1'b0;
            if (block_end)
            begin
                pos_next       = pos_reg + BLOCK_STEP;
                cur_valid_next = nxt_valid_reg;
                cur_ks_next    = nxt_ks_reg;
                nxt_valid_next = 1'b0;
                if (eng_busy)
                begin
                    job_cur_next = 1'b1;
                end
            end
        end

        if (eng_start)
        begin
            job_cur_next = !cur_valid_reg;
        end

        // A prefetch that finishes as the block turns over becomes current.
        if (eng_done)
        begin
            cancel_next = 1'b0;
            if (!cancel_reg && !restart && !cfg_hit)
            begin
                if (job_cur_reg || block_end)
                begin
                    cur_ks_next    = eng_result;
                    cur_valid_next = 1'b1;
                end
                else
                begin
                    nxt_ks_next    = eng_result;
                    nxt_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            nonce_reg     <= '0;
            start_reg     <= '0;
            pos_reg       <= '0;
            offset_reg    <= '0;
            cur_valid_reg <= 1'b0;
            nxt_valid_reg <= 1'b0;
            job_cur_reg   <= 1'b0;
            cancel_reg    <= 1'b0;
            restarted_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_reg       <= key_next;
            nonce_reg     <= nonce_next;
            start_reg     <= start_next;
            pos_reg       <= pos_next;
            offset_reg    <= offset_next;
            cur_valid_reg <= cur_valid_next;
            nxt_valid_reg <= nxt_valid_next;
            job_cur_reg   <= job_cur_next;
            cancel_reg    <= cancel_next;
            restarted_reg <= restarted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_ks_reg   <= cur_ks_next;
        nxt_ks_reg   <= nxt_ks_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

    assign status = '{emit: emit, cur_valid: cur_valid_reg,
                      eng_busy: eng_busy, eng_done: eng_done};

endmodule

[rtl/core/chacha20_stream_xor.sv]
// Top level of the byte-serial ChaCha stream XOR block.
`timescale 1ns / 1ps

// Byte-serial ChaCha stream XOR. Every request on the slave stream carries one
// byte; the block answers with that byte XORed with the next keystream byte,
// in order, one result per request, and copies tlast across. tuser marks the
// first byte of a message: it reloads the 64-bit position from start_position
// and restarts at byte zero of a fresh keystream block. The position advances
// by 64 per 64-byte block. Key, nonce and start position are written over the
// configuration channel (index 0..3 key, 4 nonce, 5 start position; other
// indexes are ignored) while the stream is idle; a write takes effect at the
// next keystream block that is built. Rate: one byte per cycle sustained while
// the output is ready. The round engine does half a quarter-round on all four
// lanes per cycle; the next block is built while the current one is consumed,
// so besides output back-pressure only a message start or a register write
// stalls the stream, until the first new block is ready. When a prefetch is
// still running at a message start, it has to run out first. A four-entry
// input queue and a registered output let either side stall independently.
module chacha20_stream_xor
    import cc_pkg::*;
#(
    parameter int ROUND_COUNT = ROUND_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    input  logic        s_axis_tlast,
    // Master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] cipher_byte
    output logic        m_axis_tlast,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic         head_valid;
    item_t        head;
    logic         pop;
    cfg_wr_t      cfg_wr;
    back_status_t status;

    // Register writes are always taken at once.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = '{valid: cfg_valid, index: cfg_index, data: cfg_data};

    cc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_first   (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    cc_back #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_wr),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata),
        .out_last   (m_axis_tlast),
        .status     (status)
    );

    // A byte is only ciphered against a finished keystream block.
    a_emit_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
        status.emit |-> status.cur_valid)
        else $error("byte emitted without a keystream block");

    // The engine reports a block only right after it has been running.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.eng_done |-> ($past(status.eng_busy) && !status.eng_busy))
        else $error("round engine finished without running");

    // An emitted byte always lands in the output register.
    a_emit_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        status.emit |=> m_axis_tvalid)
        else $error("emitted byte did not reach the output");

endmodule
